[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assert an implication on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assert that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[sv/tkps_pkg.sv]
// Types and constants of the top-k positive sum tracker.
// Used by the cell row, the score stage and the top level.
package tkps_pkg;

  localparam int VAL_W     = 31;
  localparam int SAMPLE_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam int KEEP_W    = 7;
  localparam int PEN_W     = 32;
  localparam int SCORE_W   = 64;
  localparam int BEST_W    = 63;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY    = 2'd1;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

  typedef struct packed {
    logic [VAL_W-1:0] word;
    logic             ins;
    logic             rep;
  } cell_ctl_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             occ;
    logic             gt;
    logic             le;
  } cell_link_t;

  localparam cell_link_t LEFT_EDGE  = '{val: '0, occ: 1'b1, gt: 1'b0, le: 1'b0};
  localparam cell_link_t RIGHT_EDGE = '{val: '0, occ: 1'b0, gt: 1'b0, le: 1'b0};

endpackage

[sv/tkps_cell.sv]
// One cell of the sorted row: holds one kept value and shifts with its neighbors.
// Depends on tkps_pkg.
module tkps_cell import tkps_pkg::*; (
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       occ,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;
  logic             gt;
  logic             le;

  assign gt = occ && (val_r > ctl.word);
  assign le = occ && (val_r <= ctl.word);

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins) begin
      if (left.gt) begin
        val_nxt = left.val;
      end else if (gt || (!occ && left.occ)) begin
        val_nxt = ctl.word;
      end
    end else if (ctl.rep) begin
      if (right.le) begin
        val_nxt = right.val;
      end else if (le) begin
        val_nxt = ctl.word;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign link = '{val: val_r, occ: occ, gt: gt, le: le};

endmodule

[sv/tkps_chain.sv]
// Row of sorted cells with the kept count and the running sum.
// Depends on tkps_pkg and tkps_cell.
module tkps_chain import tkps_pkg::*; #(
  parameter int MAX_KEEP = 64,
  parameter int CNT_W    = $clog2(MAX_KEEP + 1),
  parameter int SUM_W    = VAL_W + $clog2(MAX_KEEP)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                start,
  input  logic [KEEP_W-1:0]   keep_count,
  output logic [SUM_W-1:0]    sum,
  output logic [CNT_W-1:0]    total
);

  localparam int CMP_W = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] total_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [CNT_W-1:0] total_base;
  logic [SUM_W-1:0] sum_base;
  logic [CMP_W-1:0] limit;
  logic [CMP_W-1:0] total_ext;
  logic             positive;
  logic [VAL_W-1:0] word;
  cell_ctl_t        ctl;
  cell_link_t       lk [MAX_KEEP];
  logic             occ [MAX_KEEP];

  assign word       = sample[VAL_W-1:0];
  assign positive   = !sample[SAMPLE_W-1] && (word != '0);
  assign total_base = start ? '0 : total_r;
  assign sum_base   = start ? '0 : sum_r;
  assign total_ext  = CMP_W'(total_base);
  assign limit      = (CMP_W'(keep_count) > CMP_W'(MAX_KEEP)) ? CMP_W'(MAX_KEEP)
                                                               : CMP_W'(keep_count);

  always_comb begin
    ctl.word = word;
    ctl.ins  = acc && positive && (total_ext < limit);
    ctl.rep  = acc && positive && (total_ext == limit) && (total_base != '0) &&
               (word > lk[0].val);
  end

  always_comb begin
    total_nxt = total_r;
    sum_nxt   = sum_r;
    if (acc) begin
      total_nxt = total_base + CNT_W'(ctl.ins);
      sum_nxt   = sum_base;
      if (ctl.ins) begin
        sum_nxt = sum_base + SUM_W'(word);
      end else if (ctl.rep) begin
        sum_nxt = sum_base + SUM_W'(word) - SUM_W'(lk[0].val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      sum_r   <= '0;
    end else begin
      total_r <= total_nxt;
      sum_r   <= sum_nxt;
    end
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_link_t left;
    cell_link_t right;

    assign occ[i] = CMP_W'(i) < total_ext;

    if (i == 0) begin : g_left_edge
      assign left = LEFT_EDGE;
    end else begin : g_left
      assign left = lk[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_right_edge
      assign right = RIGHT_EDGE;
    end else begin : g_right
      assign right = lk[i+1];
    end

    tkps_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .occ   (occ[i]),
      .left  (left),
      .right (right),
      .link  (lk[i])
    );
  end

  assign sum   = sum_r;
  assign total = total_r;

endmodule

[sv/tkps_score.sv]
// Score and best-score stages with the result register.
// Depends on tkps_pkg; fed by the kept sum and the penalty accumulator.
module tkps_score import tkps_pkg::*; #(
  parameter int SUM_W = 37,
  parameter int CNT_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic               start,
  input  logic [SUM_W-1:0]   sum,
  input  logic [SCORE_W-1:0] pen,
  input  logic [CNT_W-1:0]   total,
  input  logic               out_stall,
  output logic               adv,
  output logic               out_valid,
  output logic [SCORE_W-1:0] out_current_score,
  output logic [BEST_W-1:0]  out_best_score,
  output logic [KEEP_W-1:0]  out_kept_now
);

  logic               pend_r;
  logic               start_r;
  logic               s3_v_r;
  logic               s3_start_r;
  logic               s3_nonneg_r;
  logic [SCORE_W-1:0] s3_score_r;
  logic [KEEP_W-1:0]  s3_kept_r;
  logic               out_v_r;
  logic [SCORE_W-1:0] out_score_r;
  logic [BEST_W-1:0]  best_r;
  logic [BEST_W-1:0]  best_nxt;
  logic [BEST_W-1:0]  best_base;
  logic [KEEP_W-1:0]  out_kept_r;
  logic [SCORE_W:0]   diff;
  logic [SCORE_W-1:0] score;

  assign adv  = !(out_v_r && out_stall);
  assign diff = {1'b0, SCORE_W'(sum)} - {1'b0, pen};

  always_comb begin
    if (diff[SCORE_W] && !diff[SCORE_W-1]) begin
      score = {1'b1, {(SCORE_W-1){1'b0}}};
    end else begin
      score = diff[SCORE_W-1:0];
    end
  end

  always_comb begin
    best_base = s3_start_r ? '0 : best_r;
    best_nxt  = best_base;
    if (s3_nonneg_r && (s3_score_r[BEST_W-1:0] > best_base)) begin
      best_nxt = s3_score_r[BEST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      best_r  <= '0;
    end else if (adv) begin
      pend_r  <= acc;
      s3_v_r  <= pend_r;
      out_v_r <= s3_v_r;
      if (s3_v_r) begin
        best_r <= best_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      start_r <= start;
    end
    if (adv) begin
      s3_start_r  <= start_r;
      s3_nonneg_r <= !diff[SCORE_W];
      s3_score_r  <= score;
      s3_kept_r   <= KEEP_W'(total);
      out_score_r <= s3_score_r;
      out_kept_r  <= s3_kept_r;
    end
  end

  assign out_valid         = out_v_r;
  assign out_current_score = out_score_r;
  assign out_best_score    = best_r;
  assign out_kept_now      = out_kept_r;

endmodule

[sv/top_k_positive_sum_tracker_top.sv]
// Top level of the top-k positive sum tracker: configuration, penalty
// accumulator, sorted cell row and score stages. Depends on tkps_pkg.
//
// Takes one sample word per clock cycle while in_stall is low and returns
// one result word per sample through the pend, s3 and result registers.
// The whole row of sorted cells compares the sample and shifts in the same
// cycle, so the only pause in intake is a stalled result: out_stall with a
// valid result freezes every stage and raises in_stall in the same cycle.
// No clearing pass runs after reset; cells beyond the kept count are ignored.
// keep_count above MAX_KEEP acts as MAX_KEEP.
module top_k_positive_sum_tracker_top import tkps_pkg::*; #(
  parameter int MAX_KEEP = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  in_sample_value,
  input  logic                 in_start_of_stream,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SCORE_W-1:0]   out_current_score,
  output logic [BEST_W-1:0]    out_best_score,
  output logic [KEEP_W-1:0]    out_kept_now,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_KEEP + 1);
  localparam int SUM_W = VAL_W + $clog2(MAX_KEEP);

  logic [KEEP_W-1:0]  keep_r;
  logic [PEN_W-1:0]   penalty_r;
  logic [SCORE_W-1:0] pen_r;
  logic [SCORE_W-1:0] pen_nxt;
  logic [SCORE_W-1:0] pen_base;
  logic [SCORE_W:0]   pen_sum;
  logic               adv;
  logic               acc;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   total;

  assign cfg_ready = 1'b1;
  assign in_stall  = !adv;
  assign acc       = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r    <= KEEP_RESET;
      penalty_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEEP_COUNT: keep_r    <= cfg_data[KEEP_W-1:0];
        REG_PENALTY:    penalty_r <= cfg_data[PEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign pen_base = in_start_of_stream ? '0 : pen_r;
  assign pen_sum  = {1'b0, pen_base} + (SCORE_W + 1)'(penalty_r);

  always_comb begin
    pen_nxt = pen_r;
    if (acc) begin
      pen_nxt = pen_sum[SCORE_W] ? '1 : pen_sum[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r <= '0;
    end else begin
      pen_r <= pen_nxt;
    end
  end

  tkps_chain #(
    .MAX_KEEP (MAX_KEEP),
    .CNT_W    (CNT_W),
    .SUM_W    (SUM_W)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .sample     (in_sample_value),
    .start      (in_start_of_stream),
    .keep_count (keep_r),
    .sum        (sum),
    .total      (total)
  );

  tkps_score #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_score (
    .clk               (clk),
    .rst_n             (rst_n),
    .acc               (acc),
    .start             (in_start_of_stream),
    .sum               (sum),
    .pen               (pen_r),
    .total             (total),
    .out_stall         (out_stall),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_current_score (out_current_score),
    .out_best_score    (out_best_score),
    .out_kept_now      (out_kept_now)
  );

endmodule

[sv/tkps_checker.sv]
// Port-level checks of the top-k positive sum tracker, bound to its top level.
// Depends on tkps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tkps_checker import tkps_pkg::*; #(
  parameter int MAX_KEEP = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SCORE_W-1:0]   out_current_score,
  input logic [BEST_W-1:0]    out_best_score,
  input logic [KEEP_W-1:0]    out_kept_now
);

  `ASSERT_CLK(a_out_hold, clk, rst_n,
              out_valid && out_stall |=> out_valid,
              "result word dropped while stalled")

  `ASSERT_CLK(a_stall_cause, clk, rst_n,
              in_stall |-> out_valid && out_stall,
              "intake stalled without a blocked result")

  `ASSERT_CLK(a_latency, clk, rst_n,
              (in_valid && !in_stall) ##1 !(out_valid && out_stall)
                ##1 !(out_valid && out_stall) |=> out_valid,
              "result word late")

  `ASSERT_CLK(a_best_floor, clk, rst_n,
              out_valid && !out_current_score[SCORE_W-1] |->
                out_best_score >= out_current_score[BEST_W-1:0],
              "best below current score")

  `ASSERT_NEVER(a_kept_bound, clk, rst_n,
                out_valid && (int'(out_kept_now) > MAX_KEEP),
                "kept count above capacity")

endmodule

bind top_k_positive_sum_tracker_top tkps_checker #(.MAX_KEEP(MAX_KEEP)) u_tkps_checker (.*);
